// ===== src/atds_pkg.sv =====
// Shared types, constants and helpers for the adjacent track duplicate selector.
package atds_pkg;

  localparam int INDEX_BITS_DEFAULT = 40;
  localparam int ENTRY_BITS         = 40;
  localparam int CFG_DATA_W         = 16;
  localparam int OUT_DEPTH          = 4;

  localparam logic [11:0] BX_WINDOW_RESET  = 12'd5;
  localparam logic [15:0] ETA_WINDOW_RESET = 16'd410;

  typedef enum logic {
    REG_BX_WINDOW  = 1'b0,
    REG_ETA_WINDOW = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0]        run_number;
    logic [31:0]        lumi_block;
    logic [31:0]        orbit;
    logic [11:0]        bunch_crossing;
    logic signed [15:0] eta_value;
    logic [7:0]         stub_count;
    logic [7:0]         bx_spread;
    logic               is_last;
  } req_t;

  typedef struct packed {
    logic [31:0]        run_number;
    logic [31:0]        lumi_block;
    logic [31:0]        orbit;
    logic [11:0]        bunch_crossing;
    logic signed [15:0] eta_value;
    logic [7:0]         stub_count;
    logic [7:0]         bx_spread;
  } cand_t;

  typedef struct packed {
    logic [ENTRY_BITS-1:0] entry_index;
    logic [31:0]           out_run;
    logic [31:0]           out_lumi;
    logic [31:0]           out_orbit;
    logic [11:0]           out_bx;
    logic signed [15:0]    out_eta;
    logic [7:0]            out_stubs;
    logic [7:0]            out_spread;
    logic                  final_flag;
  } rsp_t;

  function automatic cand_t to_cand(req_t r);
    cand_t c;
    c.run_number     = r.run_number;
    c.lumi_block     = r.lumi_block;
    c.orbit          = r.orbit;
    c.bunch_crossing = r.bunch_crossing;
    c.eta_value      = r.eta_value;
    c.stub_count     = r.stub_count;
    c.bx_spread      = r.bx_spread;
    return c;
  endfunction

  function automatic rsp_t make_rsp(cand_t c, logic [63:0] idx, logic fin);
    rsp_t o;
    o.entry_index = idx[ENTRY_BITS-1:0];
    o.out_run     = c.run_number;
    o.out_lumi    = c.lumi_block;
    o.out_orbit   = c.orbit;
    o.out_bx      = c.bunch_crossing;
    o.out_eta     = c.eta_value;
    o.out_stubs   = c.stub_count;
    o.out_spread  = c.bx_spread;
    o.final_flag  = fin;
    return o;
  endfunction

endpackage

// ===== src/atds_out_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle when not stalled.
module atds_out_fifo #(
  parameter int DEPTH = atds_pkg::OUT_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  atds_pkg::rsp_t   push_a,
  input  atds_pkg::rsp_t   push_b,
  output logic             room,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output atds_pkg::rsp_t   rsp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  atds_pkg::rsp_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] wr_ptr_b;
  logic             pop;

  assign pop        = rsp_valid && !rsp_stall;
  assign wr_ptr_b   = wr_ptr + PTR_W'(1);
  assign count_next = count + CNT_W'(push_n) - CNT_W'(pop);
  assign room       = (count <= CNT_W'(DEPTH - 2));
  assign rsp_valid  = (count != '0);
  assign rsp        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_b] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

// ===== src/adjacent_track_duplicate_selector_core.sv =====
// Top level of the adjacent track duplicate selector.
//
// Request channel (req_valid / req_stall / req) carries one track candidate per
// request. A candidate joins the previous one's group when run, lumi block and
// orbit match and the bx and eta distances are below the configured windows.
// The kept candidate of a group (largest bx spread, then most stubs, earliest on
// a tie) is sent on the result channel (rsp_valid / rsp_stall / rsp) when the
// next group starts, and also after a request flagged is_last.
// Throughput: one request per cycle when not stalled; the grouping decision
// is made in the cycle the request is taken, and its results are pushed into the
// result queue. A request can cause two results; these leave one per cycle, when
// not stalled, through a four entry result queue, and requests are stalled while
// fewer than two queue slots are free. A two-result request closes its stream,
// and the next request finds no open group and gives at most one result, so
// without result stalls the queue never holds requests back.
// A stalled result holds the queue; requests keep flowing until it fills. Reset
// clears the queue, the open group and the stream index, and loads the windows
// with bx 5 and eta 410 (0.1 in 1/4096 units). Configuration must be
// written only while idle (cfg_we/cfg_index/cfg_data); the block does not check.
module adjacent_track_duplicate_selector_core #(
  parameter int INDEX_BITS = atds_pkg::INDEX_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [atds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  atds_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output atds_pkg::rsp_t                  rsp
);

  logic [11:0]           bx_window;
  logic [15:0]           eta_window;
  logic                  have_group;
  logic [INDEX_BITS-1:0] item_count;
  logic [31:0]           last_run;
  logic [31:0]           prev_lumi;
  logic [31:0]           prev_orbit;
  logic [11:0]           prev_bx;
  logic signed [15:0]    prev_eta;
  atds_pkg::cand_t       best;
  logic [INDEX_BITS-1:0] best_index;

  logic                  req_fire;
  logic                  room;
  logic signed [12:0]    dbx;
  logic [12:0]           dbx_abs;
  logic signed [16:0]    deta;
  logic [16:0]           deta_abs;
  logic                  same;
  logic                  better;
  logic                  take;
  logic                  emit_old;
  atds_pkg::cand_t       cand;
  atds_pkg::cand_t       best_next;
  logic [INDEX_BITS-1:0] best_index_next;
  atds_pkg::rsp_t        old_rsp;
  atds_pkg::rsp_t        new_rsp;
  logic [1:0]            push_n;
  atds_pkg::rsp_t        push_a;

  assign req_stall = !room;
  assign req_fire  = req_valid && !req_stall;
  assign cand      = atds_pkg::to_cand(req);

  always_comb begin
    dbx      = $signed({1'b0, req.bunch_crossing}) - $signed({1'b0, prev_bx});
    dbx_abs  = dbx[12] ? 13'(-dbx) : 13'(dbx);
    deta     = $signed({req.eta_value[15], req.eta_value}) - $signed({prev_eta[15], prev_eta});
    deta_abs = deta[16] ? 17'(-deta) : 17'(deta);
    same     = have_group
            && (req.run_number == last_run)
            && (req.lumi_block == prev_lumi)
            && (req.orbit == prev_orbit)
            && (dbx_abs < {1'b0, bx_window})
            && (deta_abs < {1'b0, eta_window});
    better   = (req.bx_spread > best.bx_spread)
            || ((req.bx_spread == best.bx_spread) && (req.stub_count > best.stub_count));
    take     = !same || better;
    emit_old = !same && have_group;

    best_next       = take ? cand : best;
    best_index_next = take ? item_count : best_index;

    old_rsp = atds_pkg::make_rsp(best, 64'(best_index), 1'b0);
    new_rsp = atds_pkg::make_rsp(best_next, 64'(best_index_next), 1'b1);

    push_n = '0;
    push_a = new_rsp;
    if (req_fire) begin
      push_n = 2'(emit_old) + 2'(req.is_last);
      if (emit_old) begin
        push_a = old_rsp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bx_window  <= atds_pkg::BX_WINDOW_RESET;
      eta_window <= atds_pkg::ETA_WINDOW_RESET;
      have_group <= 1'b0;
      item_count <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          atds_pkg::REG_BX_WINDOW:  bx_window  <= cfg_data[11:0];
          atds_pkg::REG_ETA_WINDOW: eta_window <= cfg_data;
          default: ;
        endcase
      end
      if (req_fire) begin
        have_group <= !req.is_last;
        item_count <= req.is_last ? '0 : item_count + INDEX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      last_run   <= req.run_number;
      prev_lumi  <= req.lumi_block;
      prev_orbit <= req.orbit;
      prev_bx    <= req.bunch_crossing;
      prev_eta   <= req.eta_value;
      best       <= best_next;
      best_index <= best_index_next;
    end
  end

  atds_out_fifo #(
    .DEPTH (atds_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_a    (push_a),
    .push_b    (new_rsp),
    .room      (room),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.is_last |=> rsp_valid)
    else $error("no result after a last request");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    req_fire && req.is_last |=> !have_group)
    else $error("group still open after a last request");

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    !have_group |-> item_count == '0)
    else $error("stream index nonzero with no open group");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending right after reset");

endmodule
